// File: rtl/cgen_pkg.sv
// ----------------------------------------------------------------------------
// cgen_pkg: shared definitions for the midpoint circle generator
// Widths, opcodes, decision constants and the step record that travels from
// the front end to the point emitter.
// ----------------------------------------------------------------------------
package cgen_pkg;

    // Coordinate width of the radius; points carry one more bit for the sign.
    localparam int COORD_BITS = 10;
    localparam int CW         = COORD_BITS + 1;
    localparam int DW         = COORD_BITS + 4;

    // Input opcodes.
    localparam logic OP_START   = 1'b0;
    localparam logic OP_ADVANCE = 1'b1;

    // Midpoint decision constants.
    localparam int DEC_INIT    = 3;
    localparam int DEC_NEG_INC = 6;
    localparam int DEC_POS_INC = 10;

    // Points emitted per step and the width of the point counter.
    localparam int POINTS       = 8;
    localparam int PHASE_W      = $clog2(POINTS);
    localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(POINTS - 1);

    // Step queue between the front end and the emitter.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // One step to carry out: the octant point, the end flag, or an idle beat.
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic                 done;
        logic                 idle;
    } step_rec_t;

    // Step queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

endpackage

// File: rtl/cgen_fifo.sv
// ----------------------------------------------------------------------------
// cgen_fifo: step record queue
// A short first-in first-out store that lets the front end run ahead of the
// point emitter.
// ----------------------------------------------------------------------------
module cgen_fifo
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  cgen_pkg::step_rec_t   wr_data,
    input  logic                  rd_en,
    output cgen_pkg::step_rec_t   rd_data,
    output cgen_pkg::fifo_stat_t  stat
);

    cgen_pkg::step_rec_t mem [cgen_pkg::FIFO_DEPTH];

    logic [cgen_pkg::FIFO_AW-1:0] wr_ptr_reg;
    logic [cgen_pkg::FIFO_AW-1:0] rd_ptr_reg;
    logic [cgen_pkg::FIFO_AW:0]   count_reg;
    logic [cgen_pkg::FIFO_AW-1:0] wr_ptr_next;
    logic [cgen_pkg::FIFO_AW-1:0] rd_ptr_next;
    logic [cgen_pkg::FIFO_AW:0]   count_next;
    logic                         do_wr;
    logic                         do_rd;

    // Status and guarded strobes.
    assign stat.full  = (count_reg == (cgen_pkg::FIFO_AW + 1)'(cgen_pkg::FIFO_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_wr      = wr_en && !stat.full;
    assign do_rd      = rd_en && !stat.empty;
    assign rd_data    = mem[rd_ptr_reg];

    // Pointer and count update.
    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage write.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: rtl/cgen_front.sv
// ----------------------------------------------------------------------------
// cgen_front: command front end
// Takes start and advance beats, keeps the octant position and the midpoint
// decision, and queues one step record for every advance.
// ----------------------------------------------------------------------------
module cgen_front
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               accept,
    input  logic                               opcode,
    input  logic [cgen_pkg::COORD_BITS-1:0]    radius,
    output logic                               step_push,
    output cgen_pkg::step_rec_t                step_rec
);

    logic signed [cgen_pkg::CW-1:0] x_reg;
    logic signed [cgen_pkg::CW-1:0] y_reg;
    logic signed [cgen_pkg::DW-1:0] dec_reg;
    logic                           running_reg;
    logic signed [cgen_pkg::CW-1:0] x_next;
    logic signed [cgen_pkg::CW-1:0] y_next;
    logic signed [cgen_pkg::DW-1:0] dec_next;
    logic                           running_next;

    logic signed [cgen_pkg::CW-1:0] x_step;
    logic signed [cgen_pkg::CW-1:0] y_step;
    logic signed [cgen_pkg::DW-1:0] dec_step;
    logic signed [cgen_pkg::DW-1:0] x_dw;
    logic signed [cgen_pkg::DW-1:0] diff_dw;
    logic signed [cgen_pkg::DW-1:0] r_dw;
    logic                           done_step;

    // Midpoint update for one step from the current octant point.
    always_comb
    begin
        x_dw    = cgen_pkg::DW'(x_reg);
        diff_dw = cgen_pkg::DW'(x_reg) - cgen_pkg::DW'(y_reg);
        r_dw    = signed'(cgen_pkg::DW'(radius));
        x_step  = x_reg + cgen_pkg::CW'(1);
        if (dec_reg[cgen_pkg::DW-1])
        begin
            dec_step = dec_reg + (x_dw <<< 2) + cgen_pkg::DW'(cgen_pkg::DEC_NEG_INC);
            y_step   = y_reg;
        end
        else
        begin
            dec_step = dec_reg + (diff_dw <<< 2) + cgen_pkg::DW'(cgen_pkg::DEC_POS_INC);
            y_step   = y_reg - cgen_pkg::CW'(1);
        end
        done_step = (x_step > y_step);
    end

    // Step record and state update for the accepted beat.
    always_comb
    begin
        x_next        = x_reg;
        y_next        = y_reg;
        dec_next      = dec_reg;
        running_next  = running_reg;
        step_push     = 1'b0;
        step_rec.x    = x_reg;
        step_rec.y    = y_reg;
        step_rec.done = done_step;
        step_rec.idle = !running_reg;
        if (accept)
        begin
            if (opcode == cgen_pkg::OP_START)
            begin
                x_next       = '0;
                y_next       = signed'(cgen_pkg::CW'(radius));
                dec_next     = cgen_pkg::DW'(cgen_pkg::DEC_INIT) - (r_dw <<< 1);
                running_next = 1'b1;
            end
            else
            begin
                step_push = 1'b1;
                if (running_reg)
                begin
                    x_next       = x_step;
                    y_next       = y_step;
                    dec_next     = dec_step;
                    running_next = !done_step;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg       <= '0;
            y_reg       <= '0;
            dec_reg     <= '0;
            running_reg <= 1'b0;
        end
        else
        begin
            x_reg       <= x_next;
            y_reg       <= y_next;
            dec_reg     <= dec_next;
            running_reg <= running_next;
        end
    end

endmodule

// File: rtl/cgen_back.sv
// ----------------------------------------------------------------------------
// cgen_back: point emitter
// Walks the eight symmetric points of a step (one origin point if idle) into
// an output register, one per cycle when not stalled; pops the step with its last point.
// ----------------------------------------------------------------------------
module cgen_back
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  cgen_pkg::step_rec_t             head,
    input  logic                            head_empty,
    output logic                            head_pop,
    input  logic                            pop,
    output logic                            empty,
    output logic signed [cgen_pkg::CW-1:0]  point_x,
    output logic signed [cgen_pkg::CW-1:0]  point_y,
    output logic                            last_of_run,
    output logic                            circle_done,
    output logic                            idle_result
);

    logic [cgen_pkg::PHASE_W-1:0]   phase_reg;
    logic [cgen_pkg::PHASE_W-1:0]   phase_next;
    logic                           valid_reg;
    logic                           valid_next;
    logic signed [cgen_pkg::CW-1:0] px_reg;
    logic signed [cgen_pkg::CW-1:0] py_reg;
    logic                           last_reg;
    logic                           done_reg;
    logic                           idle_reg;

    logic                           advance;
    logic                           load;
    logic                           last_pt;
    logic signed [cgen_pkg::CW-1:0] px_sel;
    logic signed [cgen_pkg::CW-1:0] py_sel;

    // The output register takes a new point when it is free or being drained.
    assign advance  = !valid_reg || pop;
    assign load     = advance && !head_empty;
    assign last_pt  = head.idle || (phase_reg == cgen_pkg::PHASE_LAST);
    assign head_pop = load && last_pt;

    // Symmetric point for the current phase.
    always_comb
    begin
        case (phase_reg)
            3'd0:    begin px_sel =  head.x; py_sel =  head.y; end
            3'd1:    begin px_sel =  head.y; py_sel =  head.x; end
            3'd2:    begin px_sel = -head.x; py_sel =  head.y; end
            3'd3:    begin px_sel = -head.y; py_sel =  head.x; end
            3'd4:    begin px_sel =  head.x; py_sel = -head.y; end
            3'd5:    begin px_sel =  head.y; py_sel = -head.x; end
            3'd6:    begin px_sel = -head.x; py_sel = -head.y; end
            default: begin px_sel = -head.y; py_sel = -head.x; end
        endcase
        if (head.idle)
        begin
            px_sel = '0;
            py_sel = '0;
        end
    end

    // Phase counter and output valid.
    always_comb
    begin
        phase_next = phase_reg;
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = !head_empty;
        end
        if (load)
        begin
            phase_next = last_pt ? '0 : phase_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            valid_reg <= valid_next;
        end
    end

    // Output payload register.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            px_reg   <= px_sel;
            py_reg   <= py_sel;
            last_reg <= last_pt;
            done_reg <= !head.idle && last_pt && head.done;
            idle_reg <= head.idle;
        end
    end

    assign empty       = !valid_reg;
    assign point_x     = px_reg;
    assign point_y     = py_reg;
    assign last_of_run = last_reg;
    assign circle_done = done_reg;
    assign idle_result = idle_reg;

endmodule

// File: rtl/midpoint_circle_generator_core.sv
// ----------------------------------------------------------------------------
// midpoint_circle_generator_core: midpoint circle rasterizer
// Start beats load a radius; advance beats yield the eight symmetric points of
// one octant step, or one idle beat when no circle is running.
// ----------------------------------------------------------------------------
//  Channel   Handshake        Payload
//  input     push / full      opcode, radius
//  result    empty / pop      point_x, point_y, last_of_run, circle_done,
//                             idle_result
//
// Each advance beat has the front end queue a step record in a four-entry
// queue; a start beat queues none. The emitter sends one point per cycle while
// pop keeps up, so an advance yields eight results (one for an idle beat).
// full rises only when the step queue is full, so input keeps flowing while
// results wait. Reset clears the octant state, the queue and the output valid.
// ----------------------------------------------------------------------------
module midpoint_circle_generator_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic                                opcode,
    input  logic [cgen_pkg::COORD_BITS-1:0]     radius,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [cgen_pkg::CW-1:0]      point_x,
    output logic signed [cgen_pkg::CW-1:0]      point_y,
    output logic                                last_of_run,
    output logic                                circle_done,
    output logic                                idle_result
);

    cgen_pkg::fifo_stat_t fifo_stat;
    cgen_pkg::step_rec_t  push_rec;
    cgen_pkg::step_rec_t  head_rec;
    logic                 fifo_push;
    logic                 fifo_pop;
    logic                 accept;

    assign full   = fifo_stat.full;
    assign accept = push && !fifo_stat.full;

    // Command front end.
    cgen_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .opcode    (opcode),
        .radius    (radius),
        .step_push (fifo_push),
        .step_rec  (push_rec)
    );

    // Step queue.
    cgen_fifo u_fifo
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (fifo_push),
        .wr_data (push_rec),
        .rd_en   (fifo_pop),
        .rd_data (head_rec),
        .stat    (fifo_stat)
    );

    // Point emitter.
    cgen_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head_rec),
        .head_empty  (fifo_stat.empty),
        .head_pop    (fifo_pop),
        .pop         (pop),
        .empty       (empty),
        .point_x     (point_x),
        .point_y     (point_y),
        .last_of_run (last_of_run),
        .circle_done (circle_done),
        .idle_result (idle_result)
    );

`ifndef SYNTHESIS
    // The front end never queues a step into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(fifo_push && fifo_stat.full))
        else $error("step record queued while the step queue is full");

    // Circle end is only flagged on the closing point of a step.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && circle_done) |-> (last_of_run && !idle_result))
        else $error("circle_done outside the last point of a step");

    // An idle beat is a single-beat run at the origin.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && idle_result) |-> (last_of_run && point_x == 0 && point_y == 0))
        else $error("malformed idle result");

    // A point that follows a non-final point belongs to the same step.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !last_of_run) |=> (!empty && !idle_result))
        else $error("step broken before its last point");
`endif

endmodule
